// ===== sv/minv_pkg.sv =====
// minv_pkg: shared constants, sequencer states and index helper for the 4x4 inverse block
// no dependencies
package minv_pkg;

  localparam int ElemWidthDef = 32;
  localparam int FracBitsDef  = 16;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CF_A,
    ST_CF_B,
    ST_CF_MUL,
    ST_CF_WAIT,
    ST_DT_FETCH,
    ST_DT_MUL,
    ST_DT_WAIT,
    ST_DV_FETCH,
    ST_DV_GO,
    ST_DV_WAIT
  } minv_state_t;

  // n-th index of 0..3 with one index left out
  function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] e);
    skip_idx = (n >= e) ? n + 2'd1 : n;
  endfunction

endpackage

// ===== sv/minv_mul.sv =====
// minv_mul: shift-add signed multiplier, one multiplier bit per cycle
// depends on nothing but its parameters
module minv_mul #(
  parameter int W  = 32,
  parameter int PW = 136
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [W-1:0]  a,
  input  logic signed [PW-1:0] b,
  output logic signed [PW-1:0] p,
  output logic                 done
);
  localparam int CNTW = (W > 1) ? $clog2(W) : 1;
  localparam logic [CNTW-1:0] LAST = CNTW'(W - 1);

  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] bsh;
  logic [W-1:0]         abits;
  logic [CNTW-1:0]      cnt;
  logic                 busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      bsh   <= b;
      abits <= a;
      cnt   <= '0;
    end else if (busy) begin
      // sign bit of a carries negative weight
      if (abits[0]) begin
        acc <= (cnt == LAST) ? acc - bsh : acc + bsh;
      end
      bsh   <= bsh <<< 1;
      abits <= abits >> 1;
      cnt   <= cnt + 1'b1;
    end
  end

  assign p = acc;

endmodule

// ===== sv/minv_div.sv =====
// minv_div: restoring divider, one quotient bit per cycle, with overflow bit
// depends on nothing but its parameters
module minv_div #(
  parameter int W  = 32,
  parameter int XW = 200
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [XW-1:0] num,
  input  logic [XW-1:0] den,
  output logic [W-1:0]  q,
  output logic          big,
  output logic          done
);
  localparam int CNTW = $clog2(W + 1);
  localparam logic [CNTW-1:0] LAST = CNTW'(W);

  logic [XW-1:0]   r;
  logic [XW-1:0]   dsh;
  logic [W:0]      qx;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            ge;

  assign ge = (r >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= num;
      dsh <= den << W;
      qx  <= '0;
      cnt <= '0;
    end else if (busy) begin
      if (ge) begin
        r <= r - dsh;
      end
      qx  <= {qx[W-1:0], ge};
      dsh <= dsh >> 1;
      cnt <= cnt + 1'b1;
    end
  end

  assign q   = qx[W-1:0];
  assign big = qx[W];

endmodule

// ===== sv/matrix4_inverse_adjugate_top.sv =====
// matrix4_inverse_adjugate_top: 4x4 fixed-point inverse by adjugate, sequencer and stores
// depends on minv_pkg, minv_mul, minv_div
//
// Takes 16 signed Q(W-F).F elements in row-major order, one per request, then is busy
// computing the inverse and returns 16 results in row-major order, last_element on the
// sixteenth. All products run through one shift-add multiplier and all quotients through
// one restoring divider. A run needs 148 products and up to 16 quotients; input is not
// taken again until the last result has been produced. A zero determinant sets singular
// and gives zero elements; out-of-range quotients clip and set saturated.
module matrix4_inverse_adjugate_top #(
  parameter int ELEM_WIDTH = minv_pkg::ElemWidthDef,
  parameter int FRAC_BITS  = minv_pkg::FracBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ELEM_WIDTH-1:0] element_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ELEM_WIDTH-1:0] element_out,
  output logic                  last_element,
  output logic                  singular,
  output logic                  saturated
);
  import minv_pkg::*;

  localparam int W  = ELEM_WIDTH;
  localparam int CW = 3 * W + 3;
  localparam int PW = 4 * W + 8;
  localparam int XW = 5 * W + 2 * FRAC_BITS + 8;
  localparam logic [W-1:0] LIM = {1'b1, {(W-1){1'b0}}};

  minv_state_t state, state_next;

  logic [W-1:0]  mat_mem [16];
  logic [CW-1:0] adj_mem [16];
  logic [W-1:0]  mat_rd;
  logic [CW-1:0] adj_rd;
  logic [3:0]    mat_addr, adj_addr;

  logic [3:0] cnt, cof, k;
  logic [1:0] t, ph, j;
  logic [1:0] ci, cj, r0, r1, r2, c0, c1, c2, ca, cb, ct;
  logic [3:0] a_idx, b_idx;

  logic signed [W-1:0]  opa;
  logic signed [PW-1:0] x, acc, det, accn;
  logic [PW-1:0]        dmag;
  logic                 adjneg;

  logic                 mul_start, mul_done, div_start, div_done, div_big;
  logic signed [W-1:0]  mul_a;
  logic signed [PW-1:0] mul_b, mul_p;
  logic [W-1:0]         div_q;
  logic [CW-1:0]        cmag;
  logic [XW-1:0]        div_num, div_den;

  logic det_zero, rneg, rsat;
  logic [W-1:0] rval;

  // index arithmetic for cofactor (ci, cj)
  assign ci = cof[3:2];
  assign cj = cof[1:0];
  assign r0 = skip_idx(2'd0, cj);
  assign r1 = skip_idx(2'd1, cj);
  assign r2 = skip_idx(2'd2, cj);
  assign c0 = skip_idx(2'd0, ci);
  assign c1 = skip_idx(2'd1, ci);
  assign c2 = skip_idx(2'd2, ci);
  assign ca = (t == 2'd0) ? c1 : c0;
  assign cb = (t == 2'd2) ? c1 : c2;
  assign ct = (t == 2'd0) ? c0 : ((t == 2'd1) ? c1 : c2);

  always_comb begin
    case (ph)
      2'd0:    a_idx = {r1, ca};
      2'd1:    a_idx = {r2, ca};
      default: a_idx = {r0, ct};
    endcase
    b_idx = (ph == 2'd0) ? {r2, cb} : {r1, cb};
  end

  assign accn = (t == 2'd1) ? acc - mul_p : acc + mul_p;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:     if (in_valid && cnt == 4'd15) state_next = ST_CF_A;
      ST_CF_A:     state_next = ST_CF_B;
      ST_CF_B:     state_next = ST_CF_MUL;
      ST_CF_MUL:   state_next = ST_CF_WAIT;
      ST_CF_WAIT: begin
        if (mul_done) begin
          state_next = (t == 2'd2 && ph == 2'd2 && cof == 4'd15) ? ST_DT_FETCH : ST_CF_A;
        end
      end
      ST_DT_FETCH: state_next = ST_DT_MUL;
      ST_DT_MUL:   state_next = ST_DT_WAIT;
      ST_DT_WAIT: begin
        if (mul_done) state_next = (j == 2'd3) ? ST_DV_FETCH : ST_DT_FETCH;
      end
      ST_DV_FETCH: if (!out_valid || out_ready) state_next = ST_DV_GO;
      ST_DV_GO: begin
        if (det_zero) state_next = (k == 4'd15) ? ST_LOAD : ST_DV_FETCH;
        else state_next = ST_DV_WAIT;
      end
      ST_DV_WAIT: begin
        if (div_done) state_next = (k == 4'd15) ? ST_LOAD : ST_DV_FETCH;
      end
      default:     state_next = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = (state == ST_LOAD);
    mat_addr  = a_idx;
    adj_addr  = k;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_CF_B:     mat_addr = b_idx;
      ST_DT_FETCH: begin
        mat_addr = {2'b00, j};
        adj_addr = {j, 2'b00};
      end
      ST_CF_MUL:   mul_start = 1'b1;
      ST_DT_MUL:   mul_start = 1'b1;
      ST_DV_GO:    div_start = !det_zero;
      default:     mat_addr = a_idx;
    endcase
  end

  assign mul_a = (state == ST_DT_MUL) ? $signed(mat_rd) : opa;
  always_comb begin
    if (state == ST_DT_MUL) begin
      mul_b = {{(PW-CW){adj_rd[CW-1]}}, adj_rd};
    end else if (ph == 2'd2) begin
      mul_b = x;
    end else begin
      mul_b = {{(PW-W){mat_rd[W-1]}}, mat_rd};
    end
  end

  assign det_zero = (det == '0);
  assign dmag     = det[PW-1] ? PW'(-det) : PW'(det);
  assign cmag     = adj_rd[CW-1] ? CW'(-adj_rd) : adj_rd;
  assign div_num  = (XW'(cmag) << (2 * FRAC_BITS + 1)) + XW'(dmag);
  assign div_den  = XW'(dmag) << 1;

  // sign and clipping of the result to element range
  always_comb begin
    rneg = (adjneg != det[PW-1]) && (div_big || div_q != '0);
    rsat = 1'b0;
    if (rneg) begin
      if (div_big || div_q > LIM) begin
        rsat = 1'b1;
        rval = LIM;
      end else begin
        rval = W'(-div_q);
      end
    end else begin
      if (div_big || div_q > LIM - 1'b1) begin
        rsat = 1'b1;
        rval = LIM - 1'b1;
      end else begin
        rval = div_q;
      end
    end
  end

  minv_mul #(.W(W), .PW(PW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .done  (mul_done)
  );

  minv_div #(.W(W), .XW(XW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .q     (div_q),
    .big   (div_big),
    .done  (div_done)
  );

  // memories
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mat_mem[cnt] <= element_in;
    end
    mat_rd <= mat_mem[mat_addr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_CF_WAIT && mul_done && ph == 2'd2 && t == 2'd2) begin
      adj_mem[cof] <= (ci[0] ^ cj[0]) ? CW'(-accn) : CW'(accn);
    end
    adj_rd <= adj_mem[adj_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      cof       <= '0;
      k         <= '0;
      t         <= '0;
      ph        <= '0;
      j         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (in_valid) begin
            cnt <= cnt + 1'b1;
          end
          cof <= '0;
          k   <= '0;
          t   <= '0;
          ph  <= '0;
          j   <= '0;
        end
        ST_CF_WAIT: begin
          if (mul_done) begin
            if (ph == 2'd2) begin
              ph <= '0;
              if (t == 2'd2) begin
                t   <= '0;
                cof <= cof + 1'b1;
              end else begin
                t <= t + 1'b1;
              end
            end else begin
              ph <= ph + 1'b1;
            end
          end
        end
        ST_DT_WAIT: if (mul_done) j <= j + 1'b1;
        ST_DV_GO: begin
          if (det_zero) begin
            out_valid <= 1'b1;
            k         <= k + 1'b1;
          end
        end
        ST_DV_WAIT: begin
          if (div_done) begin
            out_valid <= 1'b1;
            k         <= k + 1'b1;
          end
        end
        default: cnt <= cnt;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        acc <= '0;
        det <= '0;
      end
      ST_CF_B: opa <= mat_rd;
      ST_CF_WAIT: begin
        if (mul_done) begin
          case (ph)
            2'd0:    x <= mul_p;
            2'd1:    x <= x - mul_p;
            default: acc <= (t == 2'd2) ? '0 : accn;
          endcase
        end
      end
      ST_DT_WAIT: if (mul_done) det <= det + mul_p;
      ST_DV_GO: begin
        adjneg <= adj_rd[CW-1];
        if (det_zero) begin
          element_out  <= '0;
          last_element <= (k == 4'd15);
          singular     <= 1'b1;
          saturated    <= 1'b0;
        end
      end
      ST_DV_WAIT: begin
        if (div_done) begin
          element_out  <= rval;
          last_element <= (k == 4'd15);
          singular     <= 1'b0;
          saturated    <= rsat;
        end
      end
      default: opa <= opa;
    endcase
  end

endmodule

// ===== dv/tb.sv =====
// tb: self-checking testbench for matrix4_inverse_adjugate_top, 4x4 fixed-point inverse
// depends on minv_pkg and the block under test; predicts each inverse with exact wide math
module tb;
  import minv_pkg::*;

  localparam int W = ElemWidthDef;
  localparam int F = FracBitsDef;
  typedef logic signed [255:0] wide_t;
  typedef logic [255:0] uwide_t;
  typedef struct packed {
    logic [W-1:0] elem;
    logic last;
    logic sing;
    logic sat;
  } inv_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [W-1:0] element_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [W-1:0] element_out;
  logic last_element, singular, saturated;

  logic [W-1:0] request_q[$];
  inv_result_t inverse_q[$];
  logic [W-1:0] loaded[16];
  int load_idx = 0;
  int acc_cnt = 0, sent_cnt = 0, res_cnt = 0, res_seen_drv = 0;
  int in_gap = 0, out_hold = 0, errors = 0;
  bit long_hold_done = 0;

  matrix4_inverse_adjugate_top dut (.*);

  initial forever #5 clk = ~clk;

  task automatic report(input string what, input logic [W-1:0] got, input logic [W-1:0] want);
    $display("mismatch %s at result %0d: got %h expected %h", what, res_cnt, got, want);
    errors++;
  endtask

  function automatic wide_t elem_w(input int r, input int c);
    return wide_t'(signed'(loaded[r*4+c]));
  endfunction

  function automatic wide_t minor3(input int r0, r1, r2, c0, c1, c2);
    wide_t a, b, c;
    a = elem_w(r0, c0) * (elem_w(r1, c1) * elem_w(r2, c2) - elem_w(r2, c1) * elem_w(r1, c2));
    b = elem_w(r0, c1) * (elem_w(r1, c0) * elem_w(r2, c2) - elem_w(r2, c0) * elem_w(r1, c2));
    c = elem_w(r0, c2) * (elem_w(r1, c0) * elem_w(r2, c1) - elem_w(r2, c0) * elem_w(r1, c1));
    return a - b + c;
  endfunction

  task automatic predict_inverse();
    wide_t adj[16];
    wide_t det, dmag, num, m;
    logic [255:0] q, lim;
    int rs[3], cs[3];
    int n;
    bit neg;
    inv_result_t r;
    lim = 256'd1 << (W - 1);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        n = 0;
        for (int k = 0; k < 4; k++) if (k != j) begin rs[n] = k; n++; end
        n = 0;
        for (int k = 0; k < 4; k++) if (k != i) begin cs[n] = k; n++; end
        m = minor3(rs[0], rs[1], rs[2], cs[0], cs[1], cs[2]);
        adj[i*4+j] = ((i + j) % 2) ? -m : m;
      end
    end
    det = 0;
    for (int j = 0; j < 4; j++) det += elem_w(0, j) * adj[j*4];
    dmag = det < 0 ? -det : det;
    for (int k = 0; k < 16; k++) begin
      r = '0;
      r.last = (k == 15);
      r.sing = (det == 0);
      if (det != 0) begin
        num = adj[k] < 0 ? -adj[k] : adj[k];
        neg = (adj[k] < 0) != (det < 0);
        q = ((uwide_t'(num) << (2*F + 1)) + uwide_t'(dmag))
            / (uwide_t'(dmag) << 1);
        if (q == 0) neg = 0;
        if (neg) begin
          if (q > lim) begin q = lim; r.sat = 1; end
          r.elem = W'(-q);
        end else begin
          if (q > lim - 1) begin q = lim - 1; r.sat = 1; end
          r.elem = W'(q);
        end
      end
      inverse_q.push_back(r);
    end
  endtask

  // monitor
  always @(posedge clk) begin
    inv_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        loaded[load_idx] = element_in;
        load_idx = (load_idx + 1) % 16;
        acc_cnt++;
        if (load_idx == 0) predict_inverse();
      end
      if (out_valid && out_ready) begin
        if (inverse_q.size() == 0) begin
          report("unexpected result", element_out, '0);
        end else begin
          want = inverse_q.pop_front();
          if (element_out !== want.elem) report("element_out", element_out, want.elem);
          if (last_element !== want.last) begin
            report("last_element", W'(last_element), W'(want.last));
          end
          if (singular !== want.sing) report("singular", W'(singular), W'(want.sing));
          if (saturated !== want.sat) report("saturated", W'(saturated), W'(want.sat));
        end
        res_cnt++;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && acc_cnt != sent_cnt) begin
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (sent_cnt == 160 && inverse_q.size() != 0) begin
        in_valid <= 1'b0;
      end else if (request_q.size() != 0) begin
        element_in <= request_q.pop_front();
        in_valid <= 1'b1;
        sent_cnt++;
        in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if ((sent_cnt / 48) % 2 == 1) in_gap = 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (res_cnt != res_seen_drv) begin
        res_seen_drv = res_cnt;
        out_hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if ((res_cnt / 64) % 2 == 1) out_hold = 0;
        if (res_cnt >= 40 && !long_hold_done) begin
          out_hold = 600;
          long_hold_done = 1;
        end
      end
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [W-1:0] rand_elem();
    logic signed [W-1:0] v;
    v = $urandom();
    return v >>> $urandom_range(0, W - 1);
  endfunction

  initial begin
    logic [W-1:0] mat[16];
    int kind;
    // saturation at both signs, full-scale extremes on the diagonal
    mat = '{default: '0};
    mat[0] = 32'sd1;
    mat[5] = -32'sd1;
    mat[10] = 32'h7fffffff;
    mat[15] = 32'h80000000;
    foreach (mat[i]) request_q.push_back(mat[i]);
    // zero determinant
    for (int i = 0; i < 16; i++) request_q.push_back('0);
    for (int n = 0; n < 18; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 16; i++) begin
        if (kind == 0) mat[i] = $urandom();
        else mat[i] = rand_elem();
      end
      if (kind == 1) for (int c = 0; c < 4; c++) mat[12+c] = mat[4+c];
      if (kind == 2) begin
        for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? rand_elem() : '0;
      end
      if (kind == 3) begin
        for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? (1 << F) : '0;
        mat[$urandom_range(0, 15)] = $urandom();
      end
      foreach (mat[i]) request_q.push_back(mat[i]);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (request_q.size() == 0 && acc_cnt == sent_cnt && !in_valid);
    wait (inverse_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && inverse_q.size() == 0) begin
      $display("PASS matrix4_inverse_adjugate_top");
    end else begin
      $display("FAIL matrix4_inverse_adjugate_top");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAIL matrix4_inverse_adjugate_top");
    $finish;
  end

endmodule
